// ===== design/wacrms_pkg.sv =====
// Shared widths, field offsets and codes of the windowed AC RMS meter.
`default_nettype none
package wacrms_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned COUNT_BITS  = 20;
  localparam int unsigned FRAC_BITS   = 8;

  localparam int unsigned PERIOD_BITS = 10;
  localparam int unsigned GAIN_BITS   = 16;
  localparam int unsigned LOOP_BITS   = 8;
  localparam int unsigned ACTION_BITS = 2;
  localparam int unsigned OUT_BITS    = 20;

  localparam int unsigned LSUM_BITS   = 32;
  localparam int unsigned SUM_BITS    = 48;
  localparam int unsigned MEAN_BITS   = 2 * SAMPLE_BITS;
  localparam int unsigned RAD_BITS    = MEAN_BITS + 2 * FRAC_BITS;
  localparam int unsigned ROOT_BITS   = RAD_BITS / 2;
  localparam int unsigned TOTAL_BITS  = ROOT_BITS + LOOP_BITS;

  localparam int unsigned DIV_CNT_BITS  = $clog2(SUM_BITS);
  localparam int unsigned SQRT_CNT_BITS = $clog2(ROOT_BITS);
  localparam int unsigned MUL_CNT_BITS  = $clog2(GAIN_BITS);

  localparam int unsigned IN_FIELD_BITS = SAMPLE_BITS + LOOP_BITS + 1;
  localparam int unsigned IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_USER_BITS = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(20);
  localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = GAIN_BITS'(80);

  localparam logic [ACTION_BITS-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_TICK   = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_START  = 2'd2;

  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PERIOD = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN   = 1'd1;

endpackage
`default_nettype wire

// ===== design/wacrms_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module wacrms_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [wacrms_pkg::SUM_BITS-1:0]   dividend_i,
  input  wire logic [wacrms_pkg::COUNT_BITS-1:0] divisor_i,
  output logic                                  done_o,
  output logic [wacrms_pkg::SUM_BITS-1:0]        quot_o
);
  import wacrms_pkg::*;

  localparam logic [DIV_CNT_BITS-1:0] LAST_STEP = DIV_CNT_BITS'(SUM_BITS - 1);

  logic                    run_q, run_d;
  logic                    done_q, done_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS:0]     rem_q, rem_d;
  logic [SUM_BITS-1:0]     dq_q, dq_d;
  logic [COUNT_BITS-1:0]   dvs_q, dvs_d;
  logic [COUNT_BITS:0]     shifted;
  logic [COUNT_BITS+1:0]   trial;

  always_comb begin
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dq_d    = dq_q;
    dvs_d   = dvs_q;
    shifted = {rem_q[COUNT_BITS-1:0], dq_q[SUM_BITS-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      dq_d  = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      if (!trial[COUNT_BITS+1]) begin
        rem_d = trial[COUNT_BITS:0];
        dq_d  = {dq_q[SUM_BITS-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        dq_d  = {dq_q[SUM_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule
`default_nettype wire

// ===== design/wacrms_sqrt.sv =====
// Bit-serial integer square root, two radicand bits and one root bit per cycle.
`default_nettype none
module wacrms_sqrt (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [wacrms_pkg::RAD_BITS-1:0]  rad_i,
  output logic                                 done_o,
  output logic [wacrms_pkg::ROOT_BITS-1:0]      root_o
);
  import wacrms_pkg::*;

  localparam logic [SQRT_CNT_BITS-1:0] LAST_STEP = SQRT_CNT_BITS'(ROOT_BITS - 1);

  logic                     run_q, run_d;
  logic                     done_q, done_d;
  logic [SQRT_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [RAD_BITS-1:0]      rad_q, rad_d;
  logic [ROOT_BITS+1:0]     rem_q, rem_d;
  logic [ROOT_BITS-1:0]     root_q, root_d;
  logic [ROOT_BITS+2:0]     remx;
  logic [ROOT_BITS+3:0]     trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    remx   = {rem_q[ROOT_BITS:0], rad_q[RAD_BITS-1 -: 2]};
    trial  = {1'b0, remx} - {2'b00, root_q, 2'b01};
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (run_q) begin
      rad_d = {rad_q[RAD_BITS-3:0], 2'b00};
      if (!trial[ROOT_BITS+3]) begin
        rem_d  = trial[ROOT_BITS+1:0];
        root_d = {root_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_d  = remx[ROOT_BITS+1:0];
        root_d = {root_q[ROOT_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

// ===== design/windowed_ac_rms_meter_unit.sv =====
// Top level of the windowed AC RMS meter: window control, accumulation and result output.
// A sample word passes through ST_ACC; a tick or start word is taken in ST_RUN.
// A tick that ends a non-empty zero window waits for the 48-step serial divider.
// A tick that ends a non-empty rms window runs 48 divider steps and 20 root steps.
// The last loop adds the averaging divide and a 16-step gain multiply, and waits in ST_EMIT
// while an earlier result word is still held. Reset is asynchronous and active low.
`default_nettype none
module windowed_ac_rms_meter_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [wacrms_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [wacrms_pkg::GAIN_BITS-1:0]      cfg_data_i,
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // sample, loop_count, channel, zero padding
  input  wire logic [wacrms_pkg::IN_DATA_BITS-1:0]   s_axis_tdata_i,
  // action
  input  wire logic [wacrms_pkg::ACTION_BITS-1:0]    s_axis_tuser_i,
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // rms_code, rms_scaled
  output logic [wacrms_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata_o,
  // tag, empty_window
  output logic [wacrms_pkg::OUT_USER_BITS-1:0]       m_axis_tuser_o
);
  import wacrms_pkg::*;

  typedef enum logic [7:0] {
    ST_RUN   = 8'b0000_0001,
    ST_ACC   = 8'b0000_0010,
    ST_ZDIV  = 8'b0000_0100,
    ST_MDIV  = 8'b0000_1000,
    ST_SQRT  = 8'b0001_0000,
    ST_ADIV  = 8'b0010_0000,
    ST_SCALE = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  localparam logic [MUL_CNT_BITS-1:0] MUL_LAST = MUL_CNT_BITS'(GAIN_BITS - 1);

  state_e                  state_q, state_d;
  logic                    busy_q, busy_d;
  logic                    in_rms_q, in_rms_d;
  logic [PERIOD_BITS-1:0]  elapsed_q, elapsed_d;
  logic [LSUM_BITS-1:0]    level_sum_q, level_sum_d;
  logic [COUNT_BITS-1:0]   count_q, count_d;
  logic [SAMPLE_BITS-1:0]  zero_q, zero_d;
  logic [SUM_BITS-1:0]     square_sum_q, square_sum_d;
  logic [TOTAL_BITS-1:0]   total_q, total_d;
  logic [LOOP_BITS-1:0]    loops_done_q, loops_done_d;
  logic [LOOP_BITS-1:0]    loops_wanted_q, loops_wanted_d;
  logic                    tag_q, tag_d;
  logic                    empty_q, empty_d;
  logic [PERIOD_BITS-1:0]  period_q, period_d;
  logic [GAIN_BITS-1:0]    gain_q, gain_d;
  logic [SAMPLE_BITS-1:0]  diff_q, diff_d;
  logic [OUT_BITS-1:0]     code_q, code_d;
  logic [OUT_BITS-1:0]     prod_hi_q, prod_hi_d;
  logic [GAIN_BITS-1:0]    prod_lo_q, prod_lo_d;
  logic [MUL_CNT_BITS-1:0] mul_cnt_q, mul_cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0]     out_code_q, out_code_d;
  logic [OUT_BITS-1:0]     out_scaled_q, out_scaled_d;
  logic                    out_tag_q, out_tag_d;
  logic                    out_empty_q, out_empty_d;

  logic                    div_start;
  logic [SUM_BITS-1:0]     div_dividend;
  logic [COUNT_BITS-1:0]   div_divisor;
  logic                    div_done;
  logic [SUM_BITS-1:0]     div_quot;
  logic                    sqrt_start;
  logic [RAD_BITS-1:0]     sqrt_rad;
  logic                    sqrt_done;
  logic [ROOT_BITS-1:0]    sqrt_root;

  logic [SAMPLE_BITS-1:0]  in_sample;
  logic [LOOP_BITS-1:0]    in_loops;
  logic                    in_channel;
  logic                    in_fire;
  logic [PERIOD_BITS-1:0]  elapsed_inc;
  logic [MEAN_BITS-1:0]    square;
  logic [OUT_BITS:0]       mul_sum;
  logic                    finish_loop;
  logic                    out_free;

  assign in_sample  = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign in_loops   = s_axis_tdata_i[SAMPLE_BITS +: LOOP_BITS];
  assign in_channel = s_axis_tdata_i[SAMPLE_BITS+LOOP_BITS];

  assign s_axis_tready_o = (state_q == ST_RUN);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign elapsed_inc     = elapsed_q + 1'b1;
  assign square          = MEAN_BITS'(diff_q) * MEAN_BITS'(diff_q);
  assign mul_sum         = {1'b0, prod_hi_q} + (prod_lo_q[0] ? {1'b0, code_q} : '0);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  always_comb begin
    period_d = period_q;
    gain_d   = gain_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PERIOD: period_d = cfg_data_i[PERIOD_BITS-1:0];
        CFG_GAIN:   gain_d   = cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_comb begin
    state_d        = state_q;
    busy_d         = busy_q;
    in_rms_d       = in_rms_q;
    elapsed_d      = elapsed_q;
    level_sum_d    = level_sum_q;
    count_d        = count_q;
    zero_d         = zero_q;
    square_sum_d   = square_sum_q;
    total_d        = total_q;
    loops_done_d   = loops_done_q;
    loops_wanted_d = loops_wanted_q;
    tag_d          = tag_q;
    empty_d        = empty_q;
    diff_d         = diff_q;
    code_d         = code_q;
    prod_hi_d      = prod_hi_q;
    prod_lo_d      = prod_lo_q;
    mul_cnt_d      = mul_cnt_q;
    out_valid_d    = out_valid_q && !m_axis_tready_i;
    out_code_d     = out_code_q;
    out_scaled_d   = out_scaled_q;
    out_tag_d      = out_tag_q;
    out_empty_d    = out_empty_q;
    div_start      = 1'b0;
    div_dividend   = '0;
    div_divisor    = '0;
    sqrt_start     = 1'b0;
    sqrt_rad       = '0;
    finish_loop    = 1'b0;

    case (state_q)
      ST_RUN: begin
        if (in_fire) begin
          case (s_axis_tuser_i)
            ACT_START: begin
              loops_wanted_d = (in_loops == '0) ? LOOP_BITS'(1) : in_loops;
              tag_d          = in_channel;
              busy_d         = 1'b1;
              in_rms_d       = 1'b0;
              elapsed_d      = '0;
              level_sum_d    = '0;
              count_d        = '0;
              square_sum_d   = '0;
              zero_d         = '0;
              total_d        = '0;
              loops_done_d   = '0;
              empty_d        = 1'b0;
            end
            ACT_SAMPLE: begin
              if (busy_q && (count_q != COUNT_MAX)) begin
                if (!in_rms_q) begin
                  diff_d = in_sample;
                end else if (in_sample >= zero_q) begin
                  diff_d = in_sample - zero_q;
                end else begin
                  diff_d = zero_q - in_sample;
                end
                state_d = ST_ACC;
              end
            end
            ACT_TICK: begin
              if (busy_q) begin
                elapsed_d = elapsed_inc;
                if (elapsed_inc >= period_q) begin
                  elapsed_d    = '0;
                  level_sum_d  = '0;
                  count_d      = '0;
                  square_sum_d = '0;
                  if (!in_rms_q) begin
                    if (count_q == '0) begin
                      zero_d   = '0;
                      empty_d  = 1'b1;
                      in_rms_d = 1'b1;
                    end else begin
                      div_start    = 1'b1;
                      div_dividend = SUM_BITS'(level_sum_q);
                      div_divisor  = count_q;
                      state_d      = ST_ZDIV;
                    end
                  end else begin
                    if (count_q == '0) begin
                      empty_d     = 1'b1;
                      finish_loop = 1'b1;
                    end else begin
                      div_start    = 1'b1;
                      div_dividend = square_sum_q;
                      div_divisor  = count_q;
                      state_d      = ST_MDIV;
                    end
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_ACC: begin
        if (in_rms_q) begin
          square_sum_d = square_sum_q + SUM_BITS'(square);
        end else begin
          level_sum_d = level_sum_q + LSUM_BITS'(diff_q);
        end
        count_d = count_q + 1'b1;
        state_d = ST_RUN;
      end
      ST_ZDIV: begin
        if (div_done) begin
          zero_d   = div_quot[SAMPLE_BITS-1:0];
          in_rms_d = 1'b1;
          state_d  = ST_RUN;
        end
      end
      ST_MDIV: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          sqrt_rad   = {div_quot[MEAN_BITS-1:0], {(2 * FRAC_BITS){1'b0}}};
          state_d    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          total_d     = total_q + TOTAL_BITS'(sqrt_root);
          finish_loop = 1'b1;
        end
      end
      ST_ADIV: begin
        if (div_done) begin
          code_d    = div_quot[OUT_BITS-1:0];
          prod_hi_d = '0;
          prod_lo_d = gain_q;
          mul_cnt_d = '0;
          state_d   = ST_SCALE;
        end
      end
      ST_SCALE: begin
        prod_hi_d = mul_sum[OUT_BITS:1];
        prod_lo_d = {mul_sum[0], prod_lo_q[GAIN_BITS-1:1]};
        mul_cnt_d = mul_cnt_q + 1'b1;
        if (mul_cnt_q == MUL_LAST) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_code_d   = code_q;
          out_scaled_d = prod_hi_q;
          out_tag_d    = tag_q;
          out_empty_d  = empty_q;
          busy_d       = 1'b0;
          state_d      = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase

    if (finish_loop) begin
      in_rms_d     = 1'b0;
      loops_done_d = loops_done_q + 1'b1;
      if (({1'b0, loops_done_q} + 1'b1) >= {1'b0, loops_wanted_q}) begin
        div_start    = 1'b1;
        div_dividend = SUM_BITS'(total_d);
        div_divisor  = COUNT_BITS'(loops_wanted_q);
        state_d      = ST_ADIV;
      end else begin
        state_d = ST_RUN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_RUN;
      busy_q         <= 1'b0;
      in_rms_q       <= 1'b0;
      elapsed_q      <= '0;
      level_sum_q    <= '0;
      count_q        <= '0;
      zero_q         <= '0;
      square_sum_q   <= '0;
      total_q        <= '0;
      loops_done_q   <= '0;
      loops_wanted_q <= LOOP_BITS'(1);
      tag_q          <= 1'b0;
      empty_q        <= 1'b0;
      period_q       <= PERIOD_RESET;
      gain_q         <= GAIN_RESET;
      mul_cnt_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      busy_q         <= busy_d;
      in_rms_q       <= in_rms_d;
      elapsed_q      <= elapsed_d;
      level_sum_q    <= level_sum_d;
      count_q        <= count_d;
      zero_q         <= zero_d;
      square_sum_q   <= square_sum_d;
      total_q        <= total_d;
      loops_done_q   <= loops_done_d;
      loops_wanted_q <= loops_wanted_d;
      tag_q          <= tag_d;
      empty_q        <= empty_d;
      period_q       <= period_d;
      gain_q         <= gain_d;
      mul_cnt_q      <= mul_cnt_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q       <= diff_d;
    code_q       <= code_d;
    prod_hi_q    <= prod_hi_d;
    prod_lo_q    <= prod_lo_d;
    out_code_q   <= out_code_d;
    out_scaled_q <= out_scaled_d;
    out_tag_q    <= out_tag_d;
    out_empty_q  <= out_empty_d;
  end

  wacrms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  wacrms_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_BITS'({out_scaled_q, out_code_q});
  assign m_axis_tuser_o  = {out_empty_q, out_tag_q};

endmodule
`default_nettype wire

// ===== design/wacrms_chk.sv =====
// Port-level checker for the windowed AC RMS meter, bound to the top level.
`default_nettype none
module wacrms_chk (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 cfg_valid_i,
  input wire logic                                 cfg_ready_o,
  input wire logic [wacrms_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input wire logic [wacrms_pkg::GAIN_BITS-1:0]      cfg_data_i,
  input wire logic                                 s_axis_tvalid_i,
  input wire logic                                 s_axis_tready_o,
  input wire logic [wacrms_pkg::IN_DATA_BITS-1:0]   s_axis_tdata_i,
  input wire logic [wacrms_pkg::ACTION_BITS-1:0]    s_axis_tuser_i,
  input wire logic                                 m_axis_tvalid_o,
  input wire logic                                 m_axis_tready_i,
  input wire logic [wacrms_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata_o,
  input wire logic [wacrms_pkg::OUT_USER_BITS-1:0]  m_axis_tuser_o
);
  import wacrms_pkg::*;

  logic cfg_seen;
  logic [IN_DATA_BITS-1:0] in_data_seen;

  assign cfg_seen     = cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_PERIOD) &&
                        (cfg_data_i == cfg_data_i);
  assign in_data_seen = s_axis_tdata_i;

  // A result word that is held back must stay offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word withdrawn while stalled");

  // A held-back result word must keep its contents.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // A start word is handled within ST_RUN, so the input is ready again at once.
  a_start_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == ACT_START) &&
      (in_data_seen == in_data_seen) |=> s_axis_tready_o)
    else $error("input not ready after a start word");

  // A new result only appears after the input has been held for the final steps.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result appeared without the closing computation");

  // The gain is below one, so the scaled value never exceeds the code.
  a_scaled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !cfg_seen |->
      (m_axis_tdata_o[2*OUT_BITS-1:OUT_BITS] <= m_axis_tdata_o[OUT_BITS-1:0]))
    else $error("scaled value larger than the code");

endmodule

bind windowed_ac_rms_meter_unit wacrms_chk u_wacrms_chk (.*);
`default_nettype wire

// ===== test/tb_windowed_ac_rms_meter_unit.sv =====
// Self-checking testbench of the windowed AC RMS meter, built around a cycle-free predictor.
`default_nettype none
module tb_windowed_ac_rms_meter_unit;
  import wacrms_pkg::*;

  localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 200;
  localparam int QUIET_LIMIT   = 4000;

  typedef struct packed {
    logic [OUT_BITS-1:0] code;
    logic [OUT_BITS-1:0] scaled;
    logic                tag;
    logic                empty;
  } rms_result_t;

  typedef struct packed {
    bit                         is_reg;
    logic [CFG_INDEX_BITS-1:0]  reg_idx;
    logic [GAIN_BITS-1:0]       reg_val;
    logic [ACTION_BITS-1:0]     action;
    logic [SAMPLE_BITS-1:0]     sample;
    logic [LOOP_BITS-1:0]       loops;
    logic                       chan;
    logic [7:0]                 rep;
    bit                         has_lit;
    rms_result_t                lit;
  } plan_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0]  cfg_index_i;
  logic [GAIN_BITS-1:0]       cfg_data_i;
  logic                       s_axis_tvalid_i;
  logic                       s_axis_tready_o;
  logic [IN_DATA_BITS-1:0]    s_axis_tdata_i;
  logic [ACTION_BITS-1:0]     s_axis_tuser_i;
  logic                       m_axis_tvalid_o;
  logic                       m_axis_tready_i;
  logic [OUT_DATA_BITS-1:0]   m_axis_tdata_o;
  logic [OUT_USER_BITS-1:0]   m_axis_tuser_o;

  windowed_ac_rms_meter_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Predictor state and its copy of the registers.
  logic                   meas_active;
  logic                   rms_half;
  logic [PERIOD_BITS-1:0] ticks;
  logic [PERIOD_BITS-1:0] period_q;
  logic [GAIN_BITS-1:0]   gain_q;
  logic [63:0]            sum_lv;
  logic [63:0]            n_lv;
  logic [63:0]            sum_sq;
  logic [63:0]            root_acc;
  logic [SAMPLE_BITS-1:0] zero_pt;
  logic [LOOP_BITS-1:0]   loops_cnt;
  logic [LOOP_BITS-1:0]   loops_tgt;
  logic                   tag_q;
  logic                   empty_q;

  rms_result_t pending_results[$];
  plan_row_t   plan[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          words_sent;
  int          results_seen;
  int          reg_writes;
  int          fail_count;
  int          quiet_cycles;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] root_floor(input logic [63:0] v);
    logic [31:0] acc;
    logic [31:0] trial;
    acc = '0;
    for (int b = 23; b >= 0; b--) begin
      trial = acc | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= v) acc = trial;
    end
    return acc;
  endfunction

  function automatic void clear_window();
    ticks  = '0;
    sum_lv = '0;
    n_lv   = '0;
    sum_sq = '0;
  endfunction

  function automatic void reset_meter();
    period_q    = PERIOD_RESET;
    gain_q      = GAIN_RESET;
    meas_active = 1'b0;
    rms_half    = 1'b0;
    clear_window();
    zero_pt     = '0;
    root_acc    = '0;
    loops_cnt   = '0;
    loops_tgt   = 8'd1;
    tag_q       = 1'b0;
    empty_q     = 1'b0;
  endfunction

  function automatic bit meter_step(input logic [ACTION_BITS-1:0] act,
                                    input logic [SAMPLE_BITS-1:0] smp,
                                    input logic [LOOP_BITS-1:0] nl, input logic ch,
                                    output rms_result_t r);
    logic [63:0] diff;
    logic [63:0] mean;
    logic [63:0] quot;
    logic [63:0] prod;
    r = '0;
    if (act == ACT_START) begin
      loops_tgt   = (nl == 0) ? 8'd1 : nl;
      tag_q       = ch;
      meas_active = 1'b1;
      rms_half    = 1'b0;
      clear_window();
      zero_pt     = '0;
      root_acc    = '0;
      loops_cnt   = '0;
      empty_q     = 1'b0;
      return 1'b0;
    end
    if (!meas_active) return 1'b0;
    if (act == ACT_SAMPLE) begin
      if (n_lv >= 64'(COUNT_MAX)) return 1'b0;
      if (rms_half) begin
        diff = (smp >= zero_pt) ? 64'(smp - zero_pt) : 64'(zero_pt - smp);
        sum_sq += diff * diff;
      end else begin
        sum_lv += 64'(smp);
      end
      n_lv++;
      return 1'b0;
    end
    if (act != ACT_TICK) return 1'b0;
    ticks = ticks + 1'b1;
    if (ticks < period_q) return 1'b0;
    if (!rms_half) begin
      if (n_lv == 0) begin
        zero_pt = '0;
        empty_q = 1'b1;
      end else begin
        quot    = sum_lv / n_lv;
        zero_pt = quot[SAMPLE_BITS-1:0];
      end
      clear_window();
      rms_half = 1'b1;
      return 1'b0;
    end
    mean = '0;
    if (n_lv == 0) empty_q = 1'b1;
    else mean = sum_sq / n_lv;
    root_acc += 64'(root_floor(mean << (2 * FRAC_BITS)));
    clear_window();
    rms_half = 1'b0;
    loops_cnt++;
    if (loops_cnt < loops_tgt) return 1'b0;
    quot     = root_acc / 64'(loops_tgt);
    r.code   = quot[OUT_BITS-1:0];
    prod     = 64'(r.code) * 64'(gain_q);
    r.scaled = prod[16 +: OUT_BITS];
    r.tag    = tag_q;
    r.empty  = empty_q;
    meas_active = 1'b0;
    return 1'b1;
  endfunction

  task automatic drive_word(input logic [ACTION_BITS-1:0] act,
                            input logic [SAMPLE_BITS-1:0] smp,
                            input logic [LOOP_BITS-1:0] nl, input logic ch,
                            input bit counted = 1'b1, input bit has_lit = 1'b0,
                            input rms_result_t lit = '0);
    rms_result_t r;
    bit          fires;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_DATA_BITS'({ch, nl, smp});
    s_axis_tuser_i  <= act;
    do @(posedge clk_i); while (!s_axis_tready_o);
    fires = meter_step(act, smp, nl, ch, r);
    if (has_lit) pending_results.push_back(lit);
    else if (fires) pending_results.push_back(r);
    if (counted) words_sent++;
  endtask

  // The meter may still be closing a window with no result owed, so a write waits it out.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [GAIN_BITS-1:0] val);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_PERIOD) period_q = val[PERIOD_BITS-1:0];
    else gain_q = val;
    reg_writes++;
  endtask

  function automatic plan_row_t word_row(input logic [ACTION_BITS-1:0] act,
                                         input logic [SAMPLE_BITS-1:0] smp,
                                         input logic [LOOP_BITS-1:0] nl, input logic ch,
                                         input int rep);
    plan_row_t row;
    row        = '0;
    row.action = act;
    row.sample = smp;
    row.loops  = nl;
    row.chan   = ch;
    row.rep    = rep[7:0];
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                        input logic [GAIN_BITS-1:0] val);
    plan_row_t row;
    row         = '0;
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic plan_row_t with_result(input plan_row_t row, input rms_result_t lit);
    row.has_lit = 1'b1;
    row.lit     = lit;
    return row;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int mode, input int centre,
                                                         input int swing);
    int v;
    if (mode == 0) return SAMPLE_BITS'($urandom_range(4095));
    if (mode == 2) return $urandom_range(1) ? 12'hFFF : 12'h000;
    v = centre + int'($urandom_range(2 * swing)) - swing;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_BITS'(v);
  endfunction

  task automatic stray_words();
    int n;
    int kind;
    n = $urandom_range(1, 3);
    repeat (n) begin
      kind = $urandom_range(2);
      drive_word((kind == 0) ? ACT_UNUSED : (kind == 1) ? ACT_SAMPLE : ACT_TICK,
                 SAMPLE_BITS'($urandom_range(4095)), LOOP_BITS'($urandom_range(255)),
                 1'($urandom_range(1)), 1'b0);
    end
  endtask

  task automatic measure(input bit big);
    logic [LOOP_BITS-1:0] nl;
    logic                 ch;
    int                   loops_n;
    int                   win_ticks;
    int                   mode;
    int                   centre;
    int                   swing;
    int                   r;
    int                   ns;
    bit                   quit;
    bit                   hollow;
    r = $urandom_range(99);
    if (big) nl = LOOP_BITS'($urandom_range(128, 255));
    else if (r < 8) nl = '0;
    else if (r < 75) nl = LOOP_BITS'($urandom_range(1, 3));
    else nl = LOOP_BITS'($urandom_range(4, 10));
    ch        = 1'($urandom_range(1));
    loops_n   = (nl == 0) ? 1 : int'(nl);
    win_ticks = (period_q == 0) ? 1 : int'(period_q);
    mode      = $urandom_range(2);
    centre    = $urandom_range(4095);
    swing     = $urandom_range(2047);
    quit      = ($urandom_range(99) < 6);
    if ($urandom_range(99) < 15) stray_words();
    drive_word(ACT_START, SAMPLE_BITS'($urandom_range(4095)), nl, ch);
    for (int l = 0; l < loops_n; l++) begin
      for (int w = 0; w < 2; w++) begin
        hollow = ($urandom_range(99) < 5);
        for (int t = 0; t < win_ticks; t++) begin
          ns = hollow ? 0 : $urandom_range(big ? 1 : 3);
          repeat (ns) drive_word(ACT_SAMPLE, pick_sample(mode, centre, swing),
                                 LOOP_BITS'($urandom_range(255)), 1'($urandom_range(1)));
          if (quit && $urandom_range(7) == 0) return;
          drive_word(ACT_TICK, SAMPLE_BITS'($urandom_range(4095)),
                     LOOP_BITS'($urandom_range(255)), 1'($urandom_range(1)));
        end
      end
    end
  endtask

  task automatic retune();
    int                     r;
    logic [PERIOD_BITS-1:0] p;
    logic [GAIN_BITS-1:0]   g;
    r = $urandom_range(99);
    if (r < 10) p = '0;
    else if (r < 80) p = PERIOD_BITS'($urandom_range(1, 3));
    else p = PERIOD_BITS'($urandom_range(4, 8));
    r = $urandom_range(99);
    if (r < 12) g = '0;
    else if (r < 24) g = '1;
    else g = GAIN_BITS'($urandom_range(65535));
    if ($urandom_range(1)) begin
      write_reg(CFG_PERIOD, GAIN_BITS'(p));
      write_reg(CFG_GAIN, g);
    end else begin
      write_reg(CFG_GAIN, g);
      write_reg(CFG_PERIOD, GAIN_BITS'(p));
    end
  endtask

  task automatic run_phase(input int words_goal, input int results_goal);
    int first_words;
    int first_results;
    int meas;
    first_words   = words_sent;
    first_results = results_seen;
    meas          = 0;
    while (words_sent - first_words < words_goal ||
           results_seen - first_results < results_goal) begin
      if (meas % 3 == 2) retune();
      measure(1'b0);
      meas++;
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : result_check
    rms_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[OUT_BITS-1:0] !== want.code) begin
          $error("rms_code: expected %0d, got %0d", want.code, m_axis_tdata_o[OUT_BITS-1:0]);
          fail_count++;
        end
        if (m_axis_tdata_o[OUT_BITS +: OUT_BITS] !== want.scaled) begin
          $error("rms_scaled: expected %0d, got %0d", want.scaled,
                 m_axis_tdata_o[OUT_BITS +: OUT_BITS]);
          fail_count++;
        end
        if (m_axis_tuser_o[0] !== want.tag) begin
          $error("tag: expected %0d, got %0d", want.tag, m_axis_tuser_o[0]);
          fail_count++;
        end
        if (m_axis_tuser_o[1] !== want.empty) begin
          $error("empty_window: expected %0d, got %0d", want.empty, m_axis_tuser_o[1]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Nothing was accepted for %0d cycles.", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    m_axis_tready_i = 1'b0;
    send_idle_pct   = 35;
    recv_idle_pct   = 47;
    words_sent      = 0;
    results_seen    = 0;
    reg_writes      = 0;
    fail_count      = 0;
    quiet_cycles    = 0;
    reset_meter();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle words, the unused action and a zero loop count, all at the reset settings.
    plan.push_back(word_row(ACT_SAMPLE, 12'hFFF, 8'd0, 1'b0, 1));
    plan.push_back(word_row(ACT_TICK, 12'h000, 8'hFF, 1'b1, 1));
    plan.push_back(word_row(ACT_UNUSED, 12'hFFF, 8'hFF, 1'b1, 1));
    plan.push_back(word_row(ACT_START, 12'h000, 8'd0, 1'b1, 1));
    plan.push_back(word_row(ACT_SAMPLE, 12'hFFF, 8'd0, 1'b0, 1));
    plan.push_back(word_row(ACT_TICK, 12'h000, 8'd0, 1'b0, 20));
    plan.push_back(word_row(ACT_SAMPLE, 12'h000, 8'd0, 1'b0, 1));
    plan.push_back(word_row(ACT_TICK, 12'h000, 8'd0, 1'b0, 19));
    plan.push_back(with_result(word_row(ACT_TICK, 12'h000, 8'd0, 1'b0, 1),
                               rms_result_t'({20'd1048320, 20'd1279, 1'b1, 1'b0})));
    // Both windows empty.
    plan.push_back(reg_row(CFG_PERIOD, 16'd1));
    plan.push_back(word_row(ACT_START, 12'h000, 8'd1, 1'b0, 1));
    plan.push_back(word_row(ACT_TICK, 12'h000, 8'd0, 1'b0, 1));
    plan.push_back(with_result(word_row(ACT_TICK, 12'h000, 8'd0, 1'b0, 1),
                               rms_result_t'({20'd0, 20'd0, 1'b0, 1'b1})));
    // Zero period, full gain, and a start that drops a running measurement.
    plan.push_back(reg_row(CFG_PERIOD, 16'd0));
    plan.push_back(reg_row(CFG_GAIN, 16'hFFFF));
    plan.push_back(word_row(ACT_START, 12'h000, 8'd255, 1'b1, 1));
    plan.push_back(word_row(ACT_SAMPLE, 12'h555, 8'd0, 1'b0, 1));
    plan.push_back(word_row(ACT_START, 12'h000, 8'd2, 1'b0, 1));
    plan.push_back(word_row(ACT_SAMPLE, 12'hAAA, 8'd0, 1'b0, 1));
    plan.push_back(word_row(ACT_SAMPLE, 12'h123, 8'd0, 1'b0, 1));
    plan.push_back(word_row(ACT_TICK, 12'h000, 8'd0, 1'b0, 1));
    plan.push_back(word_row(ACT_SAMPLE, 12'h800, 8'd0, 1'b0, 1));
    plan.push_back(word_row(ACT_TICK, 12'h000, 8'd0, 1'b0, 3));
    // The period is raised and then cut below the ticks already counted.
    plan.push_back(reg_row(CFG_PERIOD, 16'd3));
    plan.push_back(word_row(ACT_START, 12'h000, 8'd1, 1'b1, 1));
    plan.push_back(word_row(ACT_TICK, 12'h000, 8'd0, 1'b0, 1));
    plan.push_back(reg_row(CFG_PERIOD, 16'd1023));
    plan.push_back(word_row(ACT_TICK, 12'h000, 8'd0, 1'b0, 2));
    plan.push_back(reg_row(CFG_PERIOD, 16'd2));
    plan.push_back(word_row(ACT_TICK, 12'h000, 8'd0, 1'b0, 1));
    plan.push_back(word_row(ACT_SAMPLE, 12'hFFF, 8'd0, 1'b0, 1));
    plan.push_back(word_row(ACT_TICK, 12'h000, 8'd0, 1'b0, 2));

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        for (int k = 0; k < int'(plan[i].rep); k++) begin
          drive_word(plan[i].action, plan[i].sample, plan[i].loops, plan[i].chan, 1'b1,
                     plan[i].has_lit && k == int'(plan[i].rep) - 1, plan[i].lit);
        end
      end
    end

    run_phase(250, 5);
    send_idle_pct = 47;
    recv_idle_pct = 35;
    run_phase(250, 5);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_PERIOD, 16'd1);
    measure(1'b1);
    run_phase(250, 5);

    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d measurement words and checked %0d results over %0d register writes,",
             words_sent, results_seen, reg_writes);
    $display("under three idle patterns, including a long averaging run and empty windows.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
design/wacrms_pkg.sv
design/wacrms_div.sv
design/wacrms_sqrt.sv
design/windowed_ac_rms_meter_unit.sv
design/wacrms_chk.sv
test/tb_windowed_ac_rms_meter_unit.sv
